// File: hdl/sbe_pkg.sv
// Shared types and constants for the stack bytecode executor.
// No dependencies; every other file of the block but sbe_div uses this package.
`timescale 1ns / 1ps
`default_nettype none
package sbe_pkg;

   localparam int STACK_DEPTH_DEF = 256;
   localparam int CONST_DEPTH_DEF = 256;
   localparam int SLOT_SHIFT      = 3;   // eight bytes to a slot
   localparam int SLOT_W          = 32 - SLOT_SHIFT;

   typedef enum logic [3:0] {
      CMD_PRINT  = 4'd0,
      CMD_ADD    = 4'd1,
      CMD_SUB    = 4'd2,
      CMD_MUL    = 4'd3,
      CMD_DIV    = 4'd4,
      CMD_PUSHC  = 4'd5,
      CMD_POP    = 4'd6,
      CMD_RESV   = 4'd7,
      CMD_STORE  = 4'd8,
      CMD_LOAD   = 4'd9,
      CMD_DEFINE = 4'd10,
      CMD_CLEAR  = 4'd11
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_UNDER    = 3'd1,
      ST_DIVZERO  = 3'd2,
      ST_BADCONST = 3'd3,
      ST_BADOFS   = 3'd4,
      ST_UNKNOWN  = 3'd5,
      ST_OVER     = 3'd6,
      ST_HALTED   = 3'd7
   } status_type;

   typedef struct packed {
      logic [3:0]  command;
      logic [31:0] operand;
      logic [63:0] const_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        print_valid;
      logic [63:0] print_value;
      logic [8:0]  depth_now;
   } rsp_type;

   // Decoded instruction as it travels from front to back.
   typedef struct packed {
      cmd_type           cmd;
      logic [31:0]       operand;
      logic [SLOT_W-1:0] slot;
      logic [63:0]       const_value;
   } op_type;

endpackage
`default_nettype wire

// File: hdl/stack_bytecode_executor.sv
// Top level of the stack bytecode executor: front end, queue and back end.
// Depends on sbe_pkg, sbe_front and sbe_back.
//
// One request word is one instruction and gives exactly one response word.
// The back end runs one instruction at a time through its stack memory's single
// registered read port; multiply builds its result from three 32 by 32 partial
// products on one multiplier, divide takes one quotient bit a cycle and reserve
// zeroes one slot at a time. A two-word queue in front lets new words be taken
// while the back end works, and the response register lets the next instruction
// start while a response waits.
`timescale 1ns / 1ps
`default_nettype none
module stack_bytecode_executor #(
   parameter int STACK_DEPTH = sbe_pkg::STACK_DEPTH_DEF,
   parameter int CONST_DEPTH = sbe_pkg::CONST_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire sbe_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output sbe_pkg::rsp_type      rsp_data
);

   logic            q_valid;
   logic            q_pop;
   sbe_pkg::op_type q_head;

   sbe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop)
   );

   sbe_back #(
      .STACK_DEPTH (STACK_DEPTH),
      .CONST_DEPTH (CONST_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// File: hdl/sbe_front.sv
// Front end: accepts request words, decodes them and queues them for the back end.
// Depends on sbe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sbe_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire sbe_pkg::req_type req_data,
   output logic                  q_valid,
   output sbe_pkg::op_type       q_head,
   input  wire logic             q_pop
);

   sbe_pkg::op_type entry_ff [2];
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      fill_ff, fill_in;
   sbe_pkg::op_type decoded;
   logic            push;

   // Decode the incoming word.
   always_comb begin
      decoded.cmd         = sbe_pkg::cmd_type'(req_data.command);
      decoded.operand     = req_data.operand;
      decoded.slot        = req_data.operand[31:sbe_pkg::SLOT_SHIFT];
      decoded.const_value = req_data.const_value;
   end

   assign req_stall = (fill_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != 2'd0);
   assign q_head    = entry_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping of the two-entry queue.
   always_comb begin
      wr_ptr_in = push  ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule
`default_nettype wire

// File: hdl/sbe_div.sv
// Restoring divider for 64-bit unsigned operands, one quotient bit per cycle.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none
module sbe_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [63:0] divisor,
   output logic             done,
   output logic [63:0]      quotient
);

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  step_ff;
   logic [63:0] rem_ff;
   logic [63:0] quo_ff;
   logic [63:0] den_ff;
   logic [64:0] trial;
   logic [64:0] diff;

   assign trial    = {rem_ff, quo_ff[63]};
   assign diff     = trial - {1'b0, den_ff};
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= 6'd0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 6'd1;
            if (step_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Shift in one dividend bit and subtract where the divisor fits.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= 64'd0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         if (!diff[64]) begin
            rem_ff <= diff[63:0];
            quo_ff <= {quo_ff[62:0], 1'b1};
         end else begin
            rem_ff <= trial[63:0];
            quo_ff <= {quo_ff[62:0], 1'b0};
         end
      end
   end

endmodule
`default_nettype wire

// File: hdl/sbe_back.sv
// Back end: executes decoded instructions against the value stack and constant table.
// Depends on sbe_pkg and sbe_div.
`timescale 1ns / 1ps
`default_nettype none
module sbe_back #(
   parameter int STACK_DEPTH = sbe_pkg::STACK_DEPTH_DEF,
   parameter int CONST_DEPTH = sbe_pkg::CONST_DEPTH_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            q_valid,
   input  wire sbe_pkg::op_type q_head,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output sbe_pkg::rsp_type     rsp_data
);

   localparam int SW  = $clog2(STACK_DEPTH);
   localparam int SCW = $clog2(STACK_DEPTH + 1);
   localparam int CW  = (CONST_DEPTH > 1) ? $clog2(CONST_DEPTH) : 1;
   localparam int CCW = $clog2(CONST_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_RD_B, S_RD_A, S_MUL0, S_MUL1, S_MUL2, S_MUL3,
      S_DIV, S_PUSH, S_RSV, S_STORE, S_RESP
   } state_type;

   state_type          state_ff;
   sbe_pkg::op_type    op_ff;
   logic [SCW-1:0]     cnt_ff;
   logic [CCW-1:0]     ccnt_ff;
   logic               halted_ff;
   logic [SCW-1:0]     left_ff;
   logic [63:0]        b_ff;
   logic [63:0]        a_ff;
   logic [63:0]        acc_ff;
   logic [63:0]        prod_ff;
   logic [2:0]         st_ff;
   logic               pv_ff;
   logic [63:0]        pval_ff;
   logic               rsp_valid_ff;
   sbe_pkg::rsp_type   rsp_data_ff;

   logic [63:0]        stk_mem [STACK_DEPTH];
   logic [63:0]        cst_mem [CONST_DEPTH];
   logic [63:0]        stk_rd_ff;
   logic [63:0]        cst_rd_ff;

   logic [SW-1:0]      stk_rd_addr;
   logic               stk_we;
   logic [SW-1:0]      stk_wa;
   logic [63:0]        stk_wd;
   logic               cst_we;
   logic [CW-1:0]      cst_wa;

   logic [31:0]        mul_x;
   logic [31:0]        mul_y;
   logic               div_start;
   logic               div_done;
   logic [63:0]        div_q;

   logic [32:0]        slot_x;
   logic [32:0]        cnt_x;
   logic [32:0]        room_x;
   logic               full;
   logic               empty;

   sbe_pkg::status_type chk_st;
   state_type           chk_next;

   assign slot_x = 33'(op_ff.slot);
   assign cnt_x  = 33'(cnt_ff);
   assign room_x = 33'(STACK_DEPTH) - cnt_x;
   assign full   = (cnt_ff == SCW'(STACK_DEPTH));
   assign empty  = (cnt_ff == '0);
   assign q_pop  = (state_ff == S_IDLE) && q_valid;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Memory addressing and write data by state.
   always_comb begin
      stk_rd_addr = SW'(cnt_ff - SCW'(1));
      stk_we      = 1'b0;
      stk_wa      = SW'(cnt_ff);
      stk_wd      = 64'd0;
      if (state_ff == S_CHECK && op_ff.cmd == sbe_pkg::CMD_LOAD) begin
         stk_rd_addr = op_ff.slot[SW-1:0];
      end else if (state_ff == S_RD_B) begin
         stk_rd_addr = SW'(cnt_ff - SCW'(2));
      end
      case (state_ff)
         S_RD_A: begin
            stk_wa = SW'(cnt_ff - SCW'(2));
            if (op_ff.cmd == sbe_pkg::CMD_ADD) begin
               stk_we = 1'b1;
               stk_wd = stk_rd_ff + b_ff;
            end else if (op_ff.cmd == sbe_pkg::CMD_SUB) begin
               stk_we = 1'b1;
               stk_wd = stk_rd_ff - b_ff;
            end
         end
         S_MUL3: begin
            stk_we = 1'b1;
            stk_wa = SW'(cnt_ff - SCW'(2));
            stk_wd = acc_ff + {prod_ff[31:0], 32'd0};
         end
         S_DIV: begin
            stk_we = div_done;
            stk_wa = SW'(cnt_ff - SCW'(2));
            stk_wd = div_q;
         end
         S_PUSH: begin
            stk_we = 1'b1;
            stk_wd = (op_ff.cmd == sbe_pkg::CMD_PUSHC) ? cst_rd_ff : stk_rd_ff;
         end
         S_RSV: begin
            stk_we = 1'b1;
         end
         S_STORE: begin
            stk_we = 1'b1;
            stk_wa = op_ff.slot[SW-1:0];
            stk_wd = stk_rd_ff;
         end
         default: begin
            stk_we = 1'b0;
         end
      endcase
      cst_we = (state_ff == S_CHECK) && (op_ff.cmd == sbe_pkg::CMD_DEFINE) && !halted_ff
               && (ccnt_ff < CCW'(CONST_DEPTH));
      cst_wa = CW'(ccnt_ff);
   end

   // Decode-time checks: the status they give and the next step of the instruction.
   always_comb begin
      chk_st   = sbe_pkg::ST_OK;
      chk_next = S_RESP;
      if (op_ff.cmd == sbe_pkg::CMD_CLEAR) begin
         chk_st = sbe_pkg::ST_OK;
      end else if (halted_ff) begin
         chk_st = sbe_pkg::ST_HALTED;
      end else begin
         case (op_ff.cmd)
            sbe_pkg::CMD_PRINT, sbe_pkg::CMD_POP: begin
               if (empty) begin
                  chk_st = sbe_pkg::ST_UNDER;
               end else if (op_ff.cmd == sbe_pkg::CMD_PRINT) begin
                  chk_next = S_RD_A;
               end
            end
            sbe_pkg::CMD_ADD, sbe_pkg::CMD_SUB,
            sbe_pkg::CMD_MUL, sbe_pkg::CMD_DIV: begin
               if (cnt_ff < SCW'(2)) begin
                  chk_st = sbe_pkg::ST_UNDER;
               end else begin
                  chk_next = S_RD_B;
               end
            end
            sbe_pkg::CMD_PUSHC: begin
               if (op_ff.operand >= 32'(ccnt_ff)) begin
                  chk_st = sbe_pkg::ST_BADCONST;
               end else if (full) begin
                  chk_st = sbe_pkg::ST_OVER;
               end else begin
                  chk_next = S_PUSH;
               end
            end
            sbe_pkg::CMD_RESV: begin
               if (slot_x > room_x) begin
                  chk_st = sbe_pkg::ST_OVER;
               end else if (op_ff.slot != '0) begin
                  chk_next = S_RSV;
               end
            end
            sbe_pkg::CMD_STORE: begin
               if (empty) begin
                  chk_st = sbe_pkg::ST_UNDER;
               end else if (slot_x >= cnt_x) begin
                  chk_st = sbe_pkg::ST_BADOFS;
               end else begin
                  chk_next = S_STORE;
               end
            end
            sbe_pkg::CMD_LOAD: begin
               if (slot_x >= cnt_x) begin
                  chk_st = sbe_pkg::ST_BADOFS;
               end else if (full) begin
                  chk_st = sbe_pkg::ST_OVER;
               end else begin
                  chk_next = S_PUSH;
               end
            end
            sbe_pkg::CMD_DEFINE: begin
               chk_next = S_RESP;
            end
            default: begin
               chk_st = sbe_pkg::ST_UNKNOWN;
            end
         endcase
      end
   end

   // Stack memory, one write and one registered read port.
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      stk_rd_ff <= stk_mem[stk_rd_addr];
   end

   // Constant table memory.
   always_ff @(posedge clock) begin
      if (cst_we) begin
         cst_mem[cst_wa] <= op_ff.const_value;
      end
      cst_rd_ff <= cst_mem[op_ff.operand[CW-1:0]];
   end

   // Low 64 bits of the product from three 32 by 32 partial products.
   always_comb begin
      mul_x = a_ff[31:0];
      mul_y = b_ff[31:0];
      if (state_ff == S_MUL1) begin
         mul_y = b_ff[63:32];
      end else if (state_ff == S_MUL2) begin
         mul_x = a_ff[63:32];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_x * mul_y;
   end

   assign div_start = (state_ff == S_RD_A) && (op_ff.cmd == sbe_pkg::CMD_DIV)
                      && (b_ff != 64'd0);

   sbe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (stk_rd_ff),
      .divisor  (b_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Sequencer: state, counts, halt flag and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         ccnt_ff      <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The response word is raised when loaded and dropped once taken.
         if (state_ff == S_RESP && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  op_ff    <= q_head;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               st_ff    <= chk_st;
               pv_ff    <= 1'b0;
               pval_ff  <= 64'd0;
               left_ff  <= SCW'(op_ff.slot);
               state_ff <= chk_next;
               if (op_ff.cmd == sbe_pkg::CMD_CLEAR) begin
                  halted_ff <= 1'b0;
                  cnt_ff    <= '0;
               end else if (chk_st != sbe_pkg::ST_OK) begin
                  halted_ff <= 1'b1;
               end else if (op_ff.cmd == sbe_pkg::CMD_POP) begin
                  cnt_ff <= cnt_ff - SCW'(1);
               end else if (op_ff.cmd == sbe_pkg::CMD_DEFINE
                            && ccnt_ff < CCW'(CONST_DEPTH)) begin
                  ccnt_ff <= ccnt_ff + CCW'(1);
               end
            end
            S_RD_B: begin
               b_ff     <= stk_rd_ff;
               state_ff <= S_RD_A;
            end
            S_RD_A: begin
               // Print data, or the lower operand of an arithmetic step.
               a_ff <= stk_rd_ff;
               case (op_ff.cmd)
                  sbe_pkg::CMD_PRINT: begin
                     pv_ff    <= 1'b1;
                     pval_ff  <= stk_rd_ff;
                     cnt_ff   <= cnt_ff - SCW'(1);
                     state_ff <= S_RESP;
                  end
                  sbe_pkg::CMD_MUL: begin
                     state_ff <= S_MUL0;
                  end
                  sbe_pkg::CMD_DIV: begin
                     if (b_ff == 64'd0) begin
                        st_ff     <= sbe_pkg::ST_DIVZERO;
                        halted_ff <= 1'b1;
                        state_ff  <= S_RESP;
                     end else begin
                        state_ff <= S_DIV;
                     end
                  end
                  default: begin
                     cnt_ff   <= cnt_ff - SCW'(1);
                     state_ff <= S_RESP;
                  end
               endcase
            end
            S_MUL0: begin
               state_ff <= S_MUL1;
            end
            S_MUL1: begin
               acc_ff   <= prod_ff;
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               acc_ff   <= acc_ff + {prod_ff[31:0], 32'd0};
               state_ff <= S_MUL3;
            end
            S_MUL3: begin
               cnt_ff   <= cnt_ff - SCW'(1);
               state_ff <= S_RESP;
            end
            S_DIV: begin
               if (div_done) begin
                  cnt_ff   <= cnt_ff - SCW'(1);
                  state_ff <= S_RESP;
               end
            end
            S_PUSH: begin
               cnt_ff   <= cnt_ff + SCW'(1);
               state_ff <= S_RESP;
            end
            S_RSV: begin
               cnt_ff  <= cnt_ff + SCW'(1);
               left_ff <= left_ff - SCW'(1);
               if (left_ff == SCW'(1)) begin
                  state_ff <= S_RESP;
               end
            end
            S_STORE: begin
               cnt_ff   <= cnt_ff - SCW'(1);
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_data_ff.status      <= st_ff;
                  rsp_data_ff.print_valid <= pv_ff;
                  rsp_data_ff.print_value <= pval_ff;
                  rsp_data_ff.depth_now   <= 9'(cnt_ff);
                  state_ff                <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// File: hdl/sbe_checker.sv
// Port-level assertions for stack_bytecode_executor, bound to the top level.
// Depends on sbe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sbe_checker #(
   parameter int STACK_DEPTH = sbe_pkg::STACK_DEPTH_DEF
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire sbe_pkg::rsp_type rsp_data
);

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // A printed value only comes with an ok status.
   a_print_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.print_valid |-> rsp_data.status == sbe_pkg::ST_OK)
      else $error("print flagged on a failing step");

   // Without a print the value field is zero.
   a_print_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.print_valid |-> rsp_data.print_value == 64'd0)
      else $error("print value set without print");

   // Reported depth never passes the stack size.
   a_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_data.depth_now) <= 32'(STACK_DEPTH))
      else $error("depth beyond stack size");

   // Nothing leaves or is refused right after reset.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("handshake active after reset");

endmodule

bind stack_bytecode_executor sbe_checker #(.STACK_DEPTH(STACK_DEPTH)) u_sbe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the stack bytecode executor.
// Depends on sbe_pkg and stack_bytecode_executor; a directed table, a stack fill, then random words.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

   localparam int STACK_N = 256;
   localparam int CONST_N = 256;
   localparam int WATCHDOG_LIMIT = 20000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   sbe_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   sbe_pkg::rsp_type rsp_data;

   stack_bytecode_executor DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Shadow machine state.
   logic [63:0] shadow_stack [STACK_N];
   logic [63:0] shadow_consts [CONST_N];
   int unsigned shadow_depth;
   int unsigned shadow_nconst;
   bit          shadow_halted;

   sbe_pkg::rsp_type pending_rsp [$];
   int          error_count;
   int          idle_cycles;
   bit          rx_idle_on;
   bit          rx_hold;
   bit          stim_done;

   // Works out the response word of one instruction and updates the shadow state.
   function automatic sbe_pkg::rsp_type execute_word(sbe_pkg::req_type w);
      sbe_pkg::rsp_type    r;
      sbe_pkg::status_type st;
      logic [63:0] a, b;
      int unsigned slot;
      st = sbe_pkg::ST_OK;
      r = '0;
      slot = w.operand >> sbe_pkg::SLOT_SHIFT;
      if (w.command == sbe_pkg::CMD_CLEAR) begin
         shadow_halted = 1'b0;
         shadow_depth = 0;
      end else if (shadow_halted) begin
         st = sbe_pkg::ST_HALTED;
      end else begin
         case (w.command)
            sbe_pkg::CMD_PRINT: begin
               if (shadow_depth < 1) st = sbe_pkg::ST_UNDER;
               else begin
                  shadow_depth--;
                  r.print_valid = 1'b1;
                  r.print_value = shadow_stack[shadow_depth];
               end
            end
            sbe_pkg::CMD_ADD, sbe_pkg::CMD_SUB, sbe_pkg::CMD_MUL, sbe_pkg::CMD_DIV: begin
               if (shadow_depth < 2) st = sbe_pkg::ST_UNDER;
               else begin
                  b = shadow_stack[shadow_depth-1];
                  a = shadow_stack[shadow_depth-2];
                  if (w.command == sbe_pkg::CMD_DIV && b == 0) st = sbe_pkg::ST_DIVZERO;
                  else begin
                     case (w.command)
                        sbe_pkg::CMD_ADD: shadow_stack[shadow_depth-2] = a + b;
                        sbe_pkg::CMD_SUB: shadow_stack[shadow_depth-2] = a - b;
                        sbe_pkg::CMD_MUL: shadow_stack[shadow_depth-2] = a * b;
                        default: shadow_stack[shadow_depth-2] = a / b;
                     endcase
                     shadow_depth--;
                  end
               end
            end
            sbe_pkg::CMD_PUSHC: begin
               if (w.operand >= shadow_nconst) st = sbe_pkg::ST_BADCONST;
               else if (shadow_depth >= STACK_N) st = sbe_pkg::ST_OVER;
               else begin
                  shadow_stack[shadow_depth] = shadow_consts[w.operand];
                  shadow_depth++;
               end
            end
            sbe_pkg::CMD_POP: begin
               if (shadow_depth < 1) st = sbe_pkg::ST_UNDER;
               else shadow_depth--;
            end
            sbe_pkg::CMD_RESV: begin
               if (slot > STACK_N - shadow_depth) st = sbe_pkg::ST_OVER;
               else begin
                  for (int k = 0; k < slot; k++) begin
                     shadow_stack[shadow_depth] = '0;
                     shadow_depth++;
                  end
               end
            end
            sbe_pkg::CMD_STORE: begin
               if (shadow_depth < 1) st = sbe_pkg::ST_UNDER;
               else if (slot >= shadow_depth) st = sbe_pkg::ST_BADOFS;
               else begin
                  shadow_depth--;
                  shadow_stack[slot] = shadow_stack[shadow_depth];
               end
            end
            sbe_pkg::CMD_LOAD: begin
               if (slot >= shadow_depth) st = sbe_pkg::ST_BADOFS;
               else if (shadow_depth >= STACK_N) st = sbe_pkg::ST_OVER;
               else begin
                  shadow_stack[shadow_depth] = shadow_stack[slot];
                  shadow_depth++;
               end
            end
            sbe_pkg::CMD_DEFINE: begin
               if (shadow_nconst < CONST_N) begin
                  shadow_consts[shadow_nconst] = w.const_value;
                  shadow_nconst++;
               end
            end
            default: st = sbe_pkg::ST_UNKNOWN;
         endcase
         if (st != sbe_pkg::ST_OK) shadow_halted = 1'b1;
      end
      r.status = st;
      r.depth_now = shadow_depth[8:0];
      return r;
   endfunction

   // Directed table: command, operand, constant, and an optional typed-in answer.
   typedef struct {
      sbe_pkg::cmd_type    cmd;
      logic [31:0]         opnd;
      logic [63:0]         cval;
      bit                  fixed;
      sbe_pkg::status_type st;
      logic [8:0]          depth;
   } row_type;

   row_type directed_rows [$];

   function automatic void add_row(logic [3:0] c, logic [31:0] o, logic [63:0] v,
                                   bit fx = 0, sbe_pkg::status_type s = sbe_pkg::ST_OK,
                                   logic [8:0] d = 0);
      row_type row;
      row.cmd = sbe_pkg::cmd_type'(c);
      row.opnd = o;
      row.cval = v;
      row.fixed = fx;
      row.st = s;
      row.depth = d;
      directed_rows = {directed_rows, row};
   endfunction

   // Sends one word and records what it should produce.
   task automatic send_word(sbe_pkg::req_type w);
      sbe_pkg::rsp_type exp_rsp;
      while (($urandom_range(99) < 14) && !rx_hold && !stim_done && idle_cycles == 0) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      exp_rsp = execute_word(w);
      pending_rsp = {pending_rsp, exp_rsp};
   endtask

   task automatic send_cmd(logic [3:0] c, logic [31:0] o = 0, logic [63:0] v = 0);
      sbe_pkg::req_type w;
      w.command = c;
      w.operand = o;
      w.const_value = v;
      send_word(w);
   endtask

   // Random operand: mostly small slot offsets, sometimes any 32-bit value.
   function automatic logic [31:0] rand_operand(int unsigned span);
      if ($urandom_range(9) == 0) return $urandom;
      return ($urandom_range(span) << sbe_pkg::SLOT_SHIFT) | $urandom_range(7);
   endfunction

   function automatic logic [63:0] rand_value();
      case ($urandom_range(3))
         0: return '1;
         1: return 64'($urandom_range(5));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Stimulus.
   initial begin
      sbe_pkg::req_type w;
      int      pick;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      stim_done = 1'b0;
      shadow_depth = 0;
      shadow_nconst = 0;
      shadow_halted = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // After reset, extremes and each error code.
      add_row(sbe_pkg::CMD_PRINT, 0, 0, 1, sbe_pkg::ST_UNDER, 0);
      add_row(sbe_pkg::CMD_ADD, 0, 0, 1, sbe_pkg::ST_HALTED, 0);
      add_row(sbe_pkg::CMD_CLEAR, 0, 0, 1, sbe_pkg::ST_OK, 0);
      add_row(sbe_pkg::CMD_PUSHC, 0, 0, 1, sbe_pkg::ST_BADCONST, 0);
      add_row(sbe_pkg::CMD_CLEAR, 0, 0, 1, sbe_pkg::ST_OK, 0);
      add_row(sbe_pkg::CMD_DEFINE, 0, 64'hFFFF_FFFF_FFFF_FFFF, 1, sbe_pkg::ST_OK, 0);
      add_row(sbe_pkg::CMD_DEFINE, 0, 64'h0, 1, sbe_pkg::ST_OK, 0);
      add_row(sbe_pkg::CMD_PUSHC, 0, 0, 1, sbe_pkg::ST_OK, 1);
      add_row(sbe_pkg::CMD_PUSHC, 1, 0, 1, sbe_pkg::ST_OK, 2);
      add_row(sbe_pkg::CMD_DIV, 0, 0, 1, sbe_pkg::ST_DIVZERO, 2);
      add_row(sbe_pkg::CMD_CLEAR, 0, 0, 1, sbe_pkg::ST_OK, 0);
      add_row(sbe_pkg::CMD_PUSHC, 0, 0);
      add_row(sbe_pkg::CMD_PUSHC, 0, 0);
      add_row(sbe_pkg::CMD_MUL, 0, 0);
      add_row(sbe_pkg::CMD_PUSHC, 0, 0);
      add_row(sbe_pkg::CMD_ADD, 0, 0);
      add_row(sbe_pkg::CMD_PUSHC, 0, 0);
      add_row(sbe_pkg::CMD_SUB, 0, 0);
      add_row(sbe_pkg::CMD_RESV, 15, 0, 1, sbe_pkg::ST_OK, 2);
      add_row(sbe_pkg::CMD_STORE, 16, 0, 1, sbe_pkg::ST_BADOFS, 2);
      add_row(sbe_pkg::CMD_CLEAR, 0, 0, 1, sbe_pkg::ST_OK, 0);
      add_row(sbe_pkg::CMD_RESV, 32'hFFFF_FFFF, 0, 1, sbe_pkg::ST_OVER, 0);
      add_row(sbe_pkg::CMD_CLEAR, 0, 0, 1, sbe_pkg::ST_OK, 0);
      add_row(4'd15, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, sbe_pkg::ST_UNKNOWN, 0);
      add_row(sbe_pkg::CMD_CLEAR, 0, 0, 1, sbe_pkg::ST_OK, 0);
      add_row(sbe_pkg::CMD_LOAD, 0, 0, 1, sbe_pkg::ST_BADOFS, 0);

      foreach (directed_rows[i]) begin
         send_cmd(directed_rows[i].cmd, directed_rows[i].opnd, directed_rows[i].cval);
         if (directed_rows[i].fixed) begin
            pending_rsp[pending_rsp.size() - 1].status = directed_rows[i].st;
            pending_rsp[pending_rsp.size() - 1].depth_now = directed_rows[i].depth;
         end
      end
      send_cmd(sbe_pkg::CMD_CLEAR);

      // Fill the stack to the top and push past it, both by load and by constant.
      send_cmd(sbe_pkg::CMD_RESV, (STACK_N - 1) * 8);
      send_cmd(sbe_pkg::CMD_LOAD, (STACK_N - 2) * 8);
      send_cmd(sbe_pkg::CMD_LOAD, 0);
      send_cmd(sbe_pkg::CMD_CLEAR);
      send_cmd(sbe_pkg::CMD_RESV, STACK_N * 8);
      send_cmd(sbe_pkg::CMD_PUSHC, 0);
      send_cmd(sbe_pkg::CMD_CLEAR);

      // Random part: mostly well-formed programs, some noise.
      for (int n = 0; n < 1850; n++) begin
         if (n == 900) begin
            // Sender pauses until every expected word is back.
            req_valid <= 1'b0;
            while (pending_rsp.size() != 0) @(posedge clock);
         end
         if (n == 300) rx_hold = 1'b1;
         if (shadow_halted && $urandom_range(3) != 0) begin
            send_cmd(sbe_pkg::CMD_CLEAR);
            continue;
         end
         pick = $urandom_range(99);
         if (pick < 4) begin
            w = sbe_pkg::req_type'(100'({$urandom, $urandom, $urandom, $urandom}));
            send_word(w);
         end else if (pick < 10) begin
            send_cmd(sbe_pkg::CMD_DEFINE, $urandom, rand_value());
         end else if (pick < 32) begin
            send_cmd(sbe_pkg::CMD_PUSHC, (shadow_nconst > 0 && $urandom_range(19) != 0)
                     ? $urandom_range(shadow_nconst - 1) : rand_operand(300));
         end else if (pick < 52) begin
            logic [3:0] c;
            c = 4'($urandom_range(sbe_pkg::CMD_ADD, sbe_pkg::CMD_DIV));
            if (c == sbe_pkg::CMD_DIV && $urandom_range(3) == 0) c = sbe_pkg::CMD_MUL;
            send_cmd(c);
         end else if (pick < 60) begin
            send_cmd(sbe_pkg::CMD_PRINT);
         end else if (pick < 64) begin
            send_cmd(sbe_pkg::CMD_POP);
         end else if (pick < 68) begin
            send_cmd(sbe_pkg::CMD_RESV, ($urandom_range(5) == 0) ? rand_operand(300)
                     : 32'($urandom_range(40)));
         end else if (pick < 82) begin
            send_cmd(sbe_pkg::CMD_STORE, (shadow_depth > 0 && $urandom_range(7) != 0)
                     ? (($urandom_range(shadow_depth - 1) << 3) | $urandom_range(7))
                     : rand_operand(300));
         end else if (pick < 96) begin
            send_cmd(sbe_pkg::CMD_LOAD, (shadow_depth > 0 && $urandom_range(7) != 0)
                     ? (($urandom_range(shadow_depth - 1) << 3) | $urandom_range(7))
                     : rand_operand(300));
         end else begin
            send_cmd(sbe_pkg::CMD_CLEAR);
         end
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // Receiver idling, with a long hold-off and a long stretch of no idling.
   initial begin
      int hold_left;
      rsp_stall = 1'b1;
      rx_hold = 1'b0;
      hold_left = 0;
      idle_cycles = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rx_hold && hold_left == 0) hold_left = 400;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
            if (hold_left == 0) begin
               rx_hold = 1'b0;
               idle_cycles = 3000;
            end
         end else if (idle_cycles > 0) begin
            idle_cycles--;
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 14);
         end
      end
   end

   // Checks each response word against the oldest expectation.
   initial begin
      sbe_pkg::rsp_type exp_rsp;
      int      quiet;
      error_count = 0;
      quiet = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               $error("response word with nothing expected");
               error_count++;
            end else begin
               exp_rsp = pending_rsp.pop_front();
               if (rsp_data.status !== exp_rsp.status) begin
                  $error("status: expected %0d, got %0d", exp_rsp.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.print_valid !== exp_rsp.print_valid) begin
                  $error("print_valid: expected %0d, got %0d",
                         exp_rsp.print_valid, rsp_data.print_valid);
                  error_count++;
               end
               if (rsp_data.print_value !== exp_rsp.print_value) begin
                  $error("print_value: expected %h, got %h",
                         exp_rsp.print_value, rsp_data.print_value);
                  error_count++;
               end
               if (rsp_data.depth_now !== exp_rsp.depth_now) begin
                  $error("depth_now: expected %0d, got %0d",
                         exp_rsp.depth_now, rsp_data.depth_now);
                  error_count++;
               end
            end
         end
         if (stim_done && pending_rsp.size() == 0) begin
            repeat (100) @(posedge clock);
            if (rsp_valid) begin
               $error("response word with nothing expected");
               error_count++;
            end
            if (error_count == 0) $display("DONE: 0 errors");
            else $display("DONE: errors detected");
            $finish;
         end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

endmodule
`default_nettype wire

// File: files.f
hdl/sbe_pkg.sv
hdl/sbe_front.sv
hdl/sbe_div.sv
hdl/sbe_back.sv
hdl/stack_bytecode_executor.sv
hdl/sbe_checker.sv
tb/tb_top.sv
